### hw/rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte hasher.
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned LEN_POS  = 56;
    localparam logic [7:0]  BYTE_PAD = 8'h80;

    // Index 0 is the first chaining word (a).
    localparam logic [7:0][WORD_W-1:0] H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      byte_wr;
        byte_src_t byte_src;
        logic      count_bits;
        logic      load_work;
        logic      round_en;
        logic      finish;
        logic      digest_out;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic round_last;
        logic out_busy;
    } sts_t;

    function automatic logic [31:0] big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 byte-stream hasher: top level joining controller, datapath and output buffer.
//
// Input channel (in_valid/in_ready/in_data): one beat per message byte. has_byte marks
// data_byte as part of the message; end_of_message closes the message (a beat may carry
// both, the byte counting first, or end alone for an empty message).
// Output channel (out_valid/out_ready/out_data): four digest beats per message, word 0
// (most significant) first, last_word set on the fourth.
// Flow: a plain byte leaves the block ready for the next beat. The byte that completes
// a 64-byte block holds in_ready low through compression (64 rounds, then the chaining
// add). End of message feeds the pad byte, zeros and 8 length bytes through the byte
// path one per cycle, pausing for compression whenever a block fills, with an idle step
// where the zeros reach the length field and a step to load the output buffer, which
// waits while the buffer is busy. A second block is needed when the length no longer fits
// after the pad byte. The first beat is offered as the buffer loads and in_ready returns.
// The digest sits in its own output buffer, so the next message is taken while the
// four beats drain. If a second digest is ready before the first has fully drained,
// the block holds in_ready low until the buffer is free.
// Reset: chaining words go to the standard initial values, fill and bit count clear,
// the output channel empties. Each digest resets the chaining words and bit count again.
module sha256_byte_stream_hasher_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sha_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sha_pkg::out_t out_data
);

    sha_pkg::cmd_t cmd;
    sha_pkg::sts_t dp_status;
    sha_pkg::sts_t status;
    logic [255:0]  digest;
    logic          out_busy;

    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_byte       (in_data.has_byte),
        .end_of_message (in_data.end_of_message),
        .status         (status),
        .cmd            (cmd)
    );

    sha_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_data.data_byte),
        .status    (dp_status),
        .digest    (digest)
    );

    sha_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.digest_out),
        .digest    (digest),
        .busy      (out_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_comb
    begin
        status          = dp_status;
        status.out_busy = out_busy;
    end

    // an empty beat does nothing, so the block stays ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.has_byte && !in_data.end_of_message)
        |=> in_ready)
        else $error("empty beat stalled the input");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.word_index == 2'd0))
        else $error("digest did not start at word 0");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_word)
        |=> (out_valid && (out_data.word_index == $past(out_data.word_index) + 2'd1)))
        else $error("digest words out of sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_word) |=> !out_valid)
        else $error("output buffer reloaded while draining");

endmodule

### hw/rtl/sha_ctrl.sv
// Controller: message intake, padding sequence and compression scheduling.
module sha_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          has_byte,
    input  logic          end_of_message,
    input  sha_pkg::sts_t status,
    output sha_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_FINISH,
        S_DIGEST
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.byte_src = sha_pkg::SRC_DATA;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.byte_wr    = has_byte;
                    cmd.count_bits = has_byte;
                    if (has_byte && status.fill_last)
                    begin
                        cmd.load_work = 1'b1;
                        ret_next      = end_of_message ? S_PAD : S_IDLE;
                        state_next    = S_COMP;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_src = sha_pkg::SRC_PAD;
                if (status.fill_last)
                begin
                    cmd.load_work = 1'b1;
                    ret_next      = S_ZERO;
                    state_next    = S_COMP;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (status.fill_at_len)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.byte_wr  = 1'b1;
                    cmd.byte_src = sha_pkg::SRC_ZERO;
                    if (status.fill_last)
                    begin
                        cmd.load_work = 1'b1;
                        ret_next      = S_ZERO;
                        state_next    = S_COMP;
                    end
                end
            end
            S_LEN:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_src = sha_pkg::SRC_LEN;
                if (status.fill_last)
                begin
                    cmd.load_work = 1'b1;
                    ret_next      = S_DIGEST;
                    state_next    = S_COMP;
                end
            end
            S_COMP:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ret_reg;
            end
            S_DIGEST:
            begin
                // wait until the previous digest has drained
                if (!status.out_busy)
                begin
                    cmd.digest_out = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

### hw/rtl/sha_dp.sv
// Datapath: byte buffer and message schedule window, bit count, chaining and round logic.
module sha_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  sha_pkg::cmd_t cmd,
    input  logic [7:0]    data_byte,
    output sha_pkg::sts_t status,
    output logic [255:0]  digest
);

    // Bytes shift in at the bottom; after 64 bytes word 0 sits at the top.
    // The same register then serves as the 16-word schedule window.
    logic [15:0][31:0] buf_reg, buf_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       bits_reg, bits_next;
    logic [7:0][31:0]  h_reg, h_next;
    logic [7:0][31:0]  work_reg, work_next;
    logic [5:0]        round_reg, round_next;

    logic [7:0]  byte_in;
    logic [63:0] len_shift;
    logic [31:0] w0, new_w, t1, t2, ch, maj;

    assign len_shift = bits_reg << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            sha_pkg::SRC_DATA: byte_in = data_byte;
            sha_pkg::SRC_PAD:  byte_in = sha_pkg::BYTE_PAD;
            sha_pkg::SRC_ZERO: byte_in = 8'h00;
            sha_pkg::SRC_LEN:  byte_in = len_shift[63:56];
            default:           byte_in = 8'h00;
        endcase
    end

    assign w0    = buf_reg[15];
    assign new_w = sha_pkg::small1(buf_reg[1]) + buf_reg[6]
                 + sha_pkg::small0(buf_reg[14]) + w0;
    assign ch    = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj   = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]);
    assign t1    = work_reg[7] + sha_pkg::big1(work_reg[4]) + ch
                 + sha_pkg::k_const(round_reg) + w0;
    assign t2    = sha_pkg::big0(work_reg[0]) + maj;

    always_comb
    begin
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        h_next     = h_reg;
        work_next  = work_reg;
        round_next = round_reg;
        if (cmd.byte_wr)
        begin
            buf_next  = {buf_reg[15][23:0], buf_reg[14:0], byte_in};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_bits)
        begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.load_work)
        begin
            work_next  = h_reg;
            round_next = '0;
        end
        if (cmd.round_en)
        begin
            buf_next     = {buf_reg[14:0], new_w};
            work_next[0] = t1 + t2;
            work_next[1] = work_reg[0];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3] + t1;
            work_next[5] = work_reg[4];
            work_next[6] = work_reg[5];
            work_next[7] = work_reg[6];
            round_next   = round_reg + 6'd1;
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + work_reg[i];
            end
        end
        if (cmd.digest_out)
        begin
            h_next    = sha_pkg::H_INIT;
            bits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bits_reg  <= '0;
            h_reg     <= sha_pkg::H_INIT;
            round_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            h_reg     <= h_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        work_reg <= work_next;
    end

    assign status.fill_last   = (fill_reg == 6'd63);
    assign status.fill_at_len = (fill_reg == 6'(sha_pkg::LEN_POS));
    assign status.round_last  = (round_reg == 6'(sha_pkg::ROUNDS - 1));
    assign status.out_busy    = 1'b0;

    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

endmodule

### hw/rtl/sha_out.sv
// Output buffer: holds one digest and hands it out as four 64-bit beats.
module sha_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [255:0]  digest,
    output logic          busy,
    output logic          out_valid,
    input  logic          out_ready,
    output sha_pkg::out_t out_data
);

    logic [3:0][63:0] dig_reg;
    logic [1:0]       idx_reg, idx_next;
    logic             busy_reg, busy_next;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && out_ready)
        begin
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // word 0 (most significant) lands in index 3 of the packed load, so flip
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dig_reg <= {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
        end
    end

    assign busy                 = busy_reg;
    assign out_valid            = busy_reg;
    assign out_data.digest_word = dig_reg[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 2'd3);

endmodule

### test/tb.sv
// Testbench for the SHA-256 byte-stream hasher: directed and random messages checked against a built-in predictor.
`timescale 1ns / 1ps

module tb;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] RND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LEN_AT = 56;
    localparam int CALM_TAIL = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sha_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sha_pkg::out_t out_data;

    sha256_byte_stream_hasher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state
    logic [31:0] hash_h [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] msg_bits;

    sha_pkg::in_t  beats_to_send [$];
    sha_pkg::out_t digest_words_due [$];

    int unsigned real_beats;
    int unsigned msgs_queued;
    int unsigned beats_taken;
    int unsigned words_checked;
    int unsigned in_stall_cycles;
    int unsigned fails;
    int unsigned tx_gap;
    int unsigned rx_gap;
    int unsigned hold_left = 1500;
    sha_pkg::out_t want;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_reset();
        int i;
        for (i = 0; i < 8; i++)
            hash_h[i] = IV_WORDS[i];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (i = 0; i < 64; i++)
        begin
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            hash_h[i] = hash_h[i] + v[i];
    endfunction

    // One accepted beat: byte first, then padding and digest on end of message
    function automatic void absorb_beat(sha_pkg::in_t b);
        sha_pkg::out_t r;
        int i;
        if (b.has_byte)
        begin
            blk_bytes[blk_fill] = b.data_byte;
            blk_fill++;
            msg_bits = msg_bits + 64'd8;
            if (blk_fill == 64)
            begin
                hash_block();
                blk_fill = 0;
            end
        end
        if (b.end_of_message)
        begin
            blk_bytes[blk_fill] = PAD_BYTE;
            blk_fill++;
            // no room left for the length: flush this block first
            if (blk_fill > LEN_AT)
            begin
                while (blk_fill < 64)
                begin
                    blk_bytes[blk_fill] = 8'h00;
                    blk_fill++;
                end
                hash_block();
                blk_fill = 0;
            end
            while (blk_fill < LEN_AT)
            begin
                blk_bytes[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (i = 0; i < 8; i++)
                blk_bytes[LEN_AT + i] = msg_bits[63 - 8*i -: 8];
            hash_block();
            for (i = 0; i < 4; i++)
            begin
                r.digest_word = {hash_h[2*i], hash_h[2*i+1]};
                r.word_index  = i[1:0];
                r.last_word   = (i == 3);
                digest_words_due.push_back(r);
            end
            hash_reset();
        end
    endfunction

    function automatic void queue_beat(logic [7:0] d, logic hb, logic eom);
        sha_pkg::in_t b;
        b.data_byte      = d;
        b.has_byte       = hb;
        b.end_of_message = eom;
        beats_to_send.push_back(b);
        if (hb || eom)
            real_beats++;
        if (eom)
            msgs_queued++;
    endfunction

    // joined: the last byte carries the end flag; otherwise a separate end beat follows
    function automatic void queue_message(int len, bit joined, bit noisy);
        int k;
        for (k = 0; k < len; k++)
        begin
            if (noisy && $urandom_range(0, 11) == 0)
                queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_beat(8'($urandom_range(0, 255)), 1'b1, joined && (k == len - 1));
        end
        if (!joined || len == 0)
            queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endfunction

    // Sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_beat(in_data);
                beats_taken++;
            end
            if (in_valid && !in_ready)
            begin
                in_stall_cycles++;
            end
            else if (tx_gap != 0)
            begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (beats_to_send.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (beats_to_send.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                tx_gap <= $urandom_range(0, 8);
                in_valid <= 1'b0;
            end
            else
            begin
                in_data <= beats_to_send.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Receiver ready: a long hold after reset backs the block up, then short bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (beats_to_send.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            rx_gap <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Digest checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_words_due.size() == 0)
            begin
                $error("unexpected digest beat: word %h index %0d last %0b",
                       out_data.digest_word, out_data.word_index, out_data.last_word);
                fails++;
            end
            else
            begin
                want = digest_words_due.pop_front();
                words_checked++;
                if (out_data.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, out_data.digest_word);
                    fails++;
                end
                if (out_data.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, out_data.word_index);
                    fails++;
                end
                if (out_data.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0b, got %0b",
                           want.last_word, out_data.last_word);
                    fails++;
                end
            end
        end
    end

    int tricky_len [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

    initial
    begin
        int len;
        hash_reset();

        // empty message; stray data on an end-only beat must be ignored
        queue_beat(8'hff, 1'b0, 1'b1);
        // beat with neither flag does nothing
        queue_beat(8'h5a, 1'b0, 1'b0);
        // single byte carrying the end flag, both data extremes
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'hff, 1'b1, 1'b1);
        // "abc" with an idle beat inside and a separate end beat
        queue_beat(8'h61, 1'b1, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'h63, 1'b1, 1'b0);
        queue_beat(8'h9c, 1'b0, 1'b1);

        // random messages, lengths biased to the block and padding boundaries
        while (real_beats < 500)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 8);
                5, 6, 7:       len = tricky_len[$urandom_range(0, 11)];
                default:       len = $urandom_range(9, 130);
            endcase
            queue_message(len, 1'($urandom_range(0, 1)), 1'b1);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_to_send.size() != 0 || in_valid || digest_words_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("ran %0d input beats over %0d messages, %0d digest words checked",
                 beats_taken, msgs_queued, words_checked);
        $display("input held off for %0d cycles, %0d field errors", in_stall_cycles, fails);
        if (fails == 0 && digest_words_due.size() == 0)
            $display("sha256_byte_stream_hasher_core: match");
        else
            $display("sha256_byte_stream_hasher_core: mismatch");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d digest words outstanding", digest_words_due.size());
        $display("sha256_byte_stream_hasher_core: mismatch");
        $finish;
    end

endmodule
